FILE: rtl/hdr_luvw_pixel_encoder_assert.svh
// assertion macros for the hdr luvw pixel encoder
`ifndef HDR_LUVW_PIXEL_ENCODER_ASSERT_SVH
`define HDR_LUVW_PIXEL_ENCODER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HLE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// antecedent implies consequent in the next cycle
`define HLE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/hle_pkg.sv
// shared constants and table builder for the hdr luvw pixel encoder
package hle_pkg;

	localparam int CHAN_W             = 32;
	localparam int FRAC_BITS_DEF      = 16;
	localparam int LOG_TABLE_BITS_DEF = 8;
	localparam int LOG_FRAC           = 20;
	localparam int NUM_STAGES         = 10;
	localparam longint unsigned BLACK_Q32 = 64'd79806339;
	localparam logic [31:0] LOG_SCALE_RST = 32'd192937984;

	localparam logic [1:0] REG_MIN_VALUE  = 2'd0;
	localparam logic [1:0] REG_LOG_SCALE  = 2'd1;
	localparam logic [1:0] REG_QUANT_MODE = 2'd2;

	localparam logic QMODE_ROUND = 1'b0;
	localparam logic QMODE_TRUNC = 1'b1;

	// log2(1 + idx / 2^tbits) with LOG_FRAC fraction bits, by repeated squaring
	function automatic logic [LOG_FRAC-1:0] log_entry(input int unsigned idx, input int tbits);
		longint unsigned m;
		logic [LOG_FRAC-1:0] frac;
		m = (64'd1 << 30) + (longint'(idx) << (30 - tbits));
		frac = '0;
		for (int k = 0; k < LOG_FRAC; k++) begin
			m = (m * m) >> 30;
			frac = {frac[LOG_FRAC-2:0], 1'b0};
			if (m >= (64'd1 << 31)) begin
				m = m >> 1;
				frac[0] = 1'b1;
			end
		end
		return frac;
	endfunction

endpackage

FILE: rtl/hle_front.sv
// offset, clamp, max channel, dark test and log operand
module hle_front import hle_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic [1:0]        en,
	input  logic [31:0]       red_in,
	input  logic [31:0]       green_in,
	input  logic [31:0]       blue_in,
	input  logic [31:0]       min_value,
	output logic [31:0]       chan_s2 [3],
	output logic [31:0]       lmax_s2,
	output logic              dark_s2,
	output logic [32:0]       sum_s2
);

	localparam longint unsigned BP = (BLACK_Q32 + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);

	logic [31:0] chan_s1 [3];
	logic [31:0] raw [3];
	logic [32:0] diff [3];
	logic [31:0] lmax;
	logic [45:0] dark_prod;

	assign raw[0] = red_in;
	assign raw[1] = green_in;
	assign raw[2] = blue_in;

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			diff[j] = {raw[j][31], raw[j]} - {min_value[31], min_value};
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int j = 0; j < 3; j++) begin
				chan_s1[j] <= diff[j][32] ? 32'd0 : diff[j][31:0];
			end
		end
	end

	always_comb begin
		lmax = chan_s1[0];
		if (chan_s1[1] > lmax) lmax = chan_s1[1];
		if (chan_s1[2] > lmax) lmax = chan_s1[2];
		dark_prod = {14'd0, lmax} * 46'd10000;
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			chan_s2 <= chan_s1;
			lmax_s2 <= lmax;
			dark_s2 <= dark_prod < (46'd1 << FRAC_BITS);
			sum_s2  <= {1'b0, lmax} + BP[32:0];
		end
	end

endmodule

FILE: rtl/hle_div.sv
// restoring divider, eight quotient bits over four stages
module hle_div import hle_pkg::*; (
	input  logic        clk,
	input  logic [3:0]  en,
	input  logic [39:0] num,
	input  logic [31:0] den,
	output logic [7:0]  quo,
	output logic [31:0] rem
);

	logic [31:0] rem_s [4];
	logic [7:0]  quo_s [4];
	logic [7:0]  low_s [4];
	logic [31:0] den_s [4];

	for (genvar k = 0; k < 4; k++) begin : g_stage
		logic [31:0] rin, r1, r2, din;
		logic [7:0]  qin, lin;
		logic [32:0] t1, t2;
		logic        g1, g2;

		if (k == 0) begin : g_first
			assign rin = num[39:8];
			assign lin = num[7:0];
			assign qin = '0;
			assign din = den;
		end else begin : g_next
			assign rin = rem_s[k-1];
			assign lin = low_s[k-1];
			assign qin = quo_s[k-1];
			assign din = den_s[k-1];
		end

		always_comb begin
			t1 = {rin, lin[7]};
			g1 = t1 >= {1'b0, din};
			r1 = g1 ? 32'(t1 - {1'b0, din}) : t1[31:0];
			t2 = {r1, lin[6]};
			g2 = t2 >= {1'b0, din};
			r2 = g2 ? 32'(t2 - {1'b0, din}) : t2[31:0];
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k] <= r2;
				quo_s[k] <= {qin[5:0], g1, g2};
				low_s[k] <= {lin[5:0], 2'b00};
				den_s[k] <= din;
			end
		end
	end

	assign quo = quo_s[3];
	assign rem = rem_s[3];

endmodule

FILE: rtl/hle_luma.sv
// log2 of max channel plus black point, scaled and quantized
module hle_luma import hle_pkg::*; #(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic [3:0]  en,
	input  logic [32:0] sum,
	input  logic [31:0] log_scale,
	input  logic        trunc,
	output logic [7:0]  luma_byte,
	output logic [7:0]  luma_err
);

	localparam int TAB_N = 2 ** LOG_TABLE_BITS;

	logic [LOG_FRAC-1:0] log_tab [TAB_N];

	for (genvar g = 0; g < TAB_N; g++) begin : g_tab
		localparam logic [LOG_FRAC-1:0] ENT = log_entry(g, LOG_TABLE_BITS);
		assign log_tab[g] = ENT;
	end

	// stage 3: leading one and table index
	logic [5:0]                  top;
	logic [32+LOG_TABLE_BITS:0]  ext;
	logic [5:0]                  top_s3;
	logic [LOG_TABLE_BITS-1:0]   idx_s3;

	always_comb begin
		top = '0;
		for (int j = 0; j < 33; j++) begin
			if (sum[j]) top = 6'(j);
		end
		ext = {sum, {LOG_TABLE_BITS{1'b0}}} >> top;
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			top_s3 <= top;
			idx_s3 <= ext[LOG_TABLE_BITS-1:0];
		end
	end

	// stage 4: log value
	logic signed [27:0] lg;
	logic               pos_s4;
	logic [25:0]        mag_s4;

	always_comb begin
		lg = ((28'(top_s3) - 28'(FRAC_BITS)) <<< LOG_FRAC) + 28'(log_tab[idx_s3]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			pos_s4 <= lg > 0;
			mag_s4 <= lg[25:0];
		end
	end

	// stage 5: scale
	logic [57:0] prod_s5;

	always_ff @(posedge clk) begin
		if (en[2]) begin
			prod_s5 <= pos_s4 ? {32'd0, mag_s4} * {26'd0, log_scale} : '0;
		end
	end

	// stage 6: times 255 and quantize
	logic [57:0] v;
	logic [51:0] fr;
	logic [58:0] vr;
	logic [7:0]  b, e;

	always_comb begin
		v  = {prod_s5[49:0], 8'd0} - prod_s5;
		fr = {v[43:0], 8'd0} - {8'd0, v[43:0]};
		vr = {1'b0, v} + (59'd1 << 43);
		b = '0;
		e = '0;
		if (prod_s5 >= (58'd1 << 50)) begin
			b = 8'd255;
			e = trunc ? 8'd255 : 8'd0;
		end else if (trunc) begin
			if (v[57:44] > 14'd255) begin
				b = 8'd255;
				e = 8'd255;
			end else begin
				b = v[51:44];
				e = fr[51:44];
			end
		end else begin
			b = (vr[58:44] > 15'd255) ? 8'd255 : vr[51:44];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			luma_byte <= b;
			luma_err  <= e;
		end
	end

endmodule

FILE: rtl/hdr_luvw_pixel_encoder.sv
// top level of the hdr luvw pixel encoder
// Ten-stage pipeline taking one pixel per clock when not stalled by output back-pressure.
// Stages 1-2 subtract min_value, clamp and take the max channel; stages 3-6 divide each
// channel by it (two restoring steps per stage) while the log path finds the leading one,
// looks up log2, multiplies by log_scale and quantizes; stages 7-10 divide the remainder
// for the truncation error. Each stage holds or advances on its own, so bubbles close up
// under output back-pressure. Configuration writes are always taken.
module hdr_luvw_pixel_encoder import hle_pkg::*; #(
	parameter int FRAC_BITS      = FRAC_BITS_DEF,
	parameter int LOG_TABLE_BITS = LOG_TABLE_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // red_in, green_in, blue_in
	input  logic        s_axis_tlast,  // last_in
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // u_byte, v_byte, w_byte, luma_byte, u_error, v_error, w_error, luma_error
	output logic        m_axis_tlast,  // last_out
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	`include "hdr_luvw_pixel_encoder_assert.svh"

	logic [31:0] min_value_q, log_scale_q;
	logic        quant_mode_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_value_q  <= '0;
			log_scale_q  <= LOG_SCALE_RST;
			quant_mode_q <= QMODE_ROUND;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_MIN_VALUE:  min_value_q  <= cfg_data;
				REG_LOG_SCALE:  log_scale_q  <= cfg_data;
				REG_QUANT_MODE: quant_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// per-stage valid and advance
	logic [NUM_STAGES:1]   vld_q;
	logic [NUM_STAGES+1:1] adv;

	always_comb begin
		adv[NUM_STAGES+1] = m_axis_tready;
		for (int k = NUM_STAGES; k >= 1; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NUM_STAGES; k++) begin
				if (adv[k]) vld_q[k] <= (k == 1) ? s_axis_tvalid : vld_q[k-1];
			end
		end
	end

	assign s_axis_tready = adv[1];
	assign m_axis_tvalid = vld_q[NUM_STAGES];

	// front end
	logic [31:0] chan_s2 [3];
	logic [31:0] lmax_s2;
	logic        dark_s2;
	logic [32:0] sum_s2;

	hle_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk       (clk),
		.en        (adv[2:1]),
		.red_in    (s_axis_tdata[31:0]),
		.green_in  (s_axis_tdata[63:32]),
		.blue_in   (s_axis_tdata[95:64]),
		.min_value (min_value_q),
		.chan_s2   (chan_s2),
		.lmax_s2   (lmax_s2),
		.dark_s2   (dark_s2),
		.sum_s2    (sum_s2)
	);

	// ratio and error dividers
	logic [7:0]  quo_a [3];
	logic [31:0] rem_a [3];
	logic [7:0]  quo_b [3];
	logic [31:0] rem_b [3];
	logic [31:0] lmax_s6;
	logic [39:0] num_b [3];

	for (genvar j = 0; j < 3; j++) begin : g_lane
		logic [39:0] num_a;
		assign num_a    = {chan_s2[j], 8'd0} - {8'd0, chan_s2[j]};
		assign num_b[j] = {rem_a[j], 8'd0} - {8'd0, rem_a[j]};

		hle_div u_div_a (
			.clk (clk),
			.en  (adv[6:3]),
			.num (num_a),
			.den (lmax_s2),
			.quo (quo_a[j]),
			.rem (rem_a[j])
		);

		hle_div u_div_b (
			.clk (clk),
			.en  (adv[10:7]),
			.num (num_b[j]),
			.den (lmax_s6),
			.quo (quo_b[j]),
			.rem (rem_b[j])
		);
	end

	// divisor carried beside the first divider
	logic [31:0] lmax_d [3:6];

	always_ff @(posedge clk) begin
		for (int k = 3; k <= 6; k++) begin
			if (adv[k]) lmax_d[k] <= (k == 3) ? lmax_s2 : lmax_d[k-1];
		end
	end

	assign lmax_s6 = lmax_d[6];

	// quotient and round bit carried beside the error divider
	logic [7:0] quo_d [3][7:10];
	logic       rnd_d [3][7:10];

	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++) begin
			for (int k = 7; k <= 10; k++) begin
				if (adv[k]) begin
					quo_d[j][k] <= (k == 7) ? quo_a[j] : quo_d[j][k-1];
					rnd_d[j][k] <= (k == 7) ? ({rem_a[j], 1'b0} >= {1'b0, lmax_s6})
						: rnd_d[j][k-1];
				end
			end
		end
	end

	// luma path
	logic [7:0] luma_b, luma_e;

	hle_luma #(.FRAC_BITS(FRAC_BITS), .LOG_TABLE_BITS(LOG_TABLE_BITS)) u_luma (
		.clk       (clk),
		.en        (adv[6:3]),
		.sum       (sum_s2),
		.log_scale (log_scale_q),
		.trunc     (quant_mode_q),
		.luma_byte (luma_b),
		.luma_err  (luma_e)
	);

	logic [7:0] lb_d [7:10];
	logic [7:0] le_d [7:10];
	logic       dark_d [3:10];
	logic       last_d [1:10];

	always_ff @(posedge clk) begin
		for (int k = 1; k <= NUM_STAGES; k++) begin
			if (adv[k]) last_d[k] <= (k == 1) ? s_axis_tlast : last_d[k-1];
		end
		for (int k = 3; k <= NUM_STAGES; k++) begin
			if (adv[k]) dark_d[k] <= (k == 3) ? dark_s2 : dark_d[k-1];
		end
		for (int k = 7; k <= NUM_STAGES; k++) begin
			if (adv[k]) begin
				lb_d[k] <= (k == 7) ? luma_b : lb_d[k-1];
				le_d[k] <= (k == 7) ? luma_e : le_d[k-1];
			end
		end
	end

	// output select
	logic [7:0] byte_o [3];
	logic [7:0] err_o [3];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			if (dark_d[10]) begin
				byte_o[j] = 8'd255;
				err_o[j]  = 8'd0;
			end else if (quant_mode_q == QMODE_TRUNC) begin
				byte_o[j] = quo_d[j][10];
				err_o[j]  = quo_b[j];
			end else begin
				byte_o[j] = quo_d[j][10] + {7'd0, rnd_d[j][10]};
				err_o[j]  = 8'd0;
			end
		end
	end

	assign m_axis_tdata = {le_d[10], err_o[2], err_o[1], err_o[0],
		lb_d[10], byte_o[2], byte_o[1], byte_o[0]};
	assign m_axis_tlast = last_d[10];

	`HLE_ASSERT_NOW(a_dark_full, m_axis_tvalid && dark_d[10],
		m_axis_tdata[23:0] == 24'hffffff && m_axis_tdata[55:32] == 24'd0,
		"dark pixel bytes wrong")
	`HLE_ASSERT_NOW(a_round_no_err, m_axis_tvalid && quant_mode_q == QMODE_ROUND,
		m_axis_tdata[63:32] == 32'd0, "error bytes set in round mode")
	`HLE_ASSERT_NOW(a_empty_ready, !vld_q[NUM_STAGES], s_axis_tready,
		"input stalled with empty output stage")
	`HLE_ASSERT_NEXT(a_stall_hold, vld_q[NUM_STAGES] && !m_axis_tready,
		vld_q[NUM_STAGES] && $stable(last_d[10]), "stalled result lost")

endmodule

FILE: tb/tb_hdr_luvw_pixel_encoder.sv
// testbench for the hdr luvw pixel encoder: directed table and random pixels checked by a predictor
module tb_hdr_luvw_pixel_encoder;
	import hle_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC = 16;
	localparam int TBITS = 8;
	localparam longint unsigned BLACK_PT = (BLACK_Q32 + (64'd1 << (31 - FRAC))) >> (32 - FRAC);
	localparam int IDLE_LIMIT = 3000;

	typedef struct {
		logic [7:0] f [8];
		logic       last;
	} pix_res_t;

	typedef struct {
		logic [31:0] r, g, b;
		logic        last;
		logic        typed;
		logic [63:0] exp;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata;
	logic        s_axis_tlast;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [63:0] m_axis_tdata;
	logic        m_axis_tlast;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [31:0] cfg_data;

	logic [31:0] min_off;
	logic [31:0] lscale;
	logic        qmode;
	logic [19:0] log2_tab [256];
	pix_res_t    pending_pix [$];
	int          mismatch_cnt;
	int          idle_cyc;
	int          hold_cnt;
	int          stall_cnt;
	int          hold_seq;
	int          hold_seen;
	logic        quiet;
	string       fname [8] = '{"u_byte", "v_byte", "w_byte", "luma_byte",
		"u_error", "v_error", "w_error", "luma_error"};

	hdr_luvw_pixel_encoder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [19:0] log2_frac(input int unsigned i);
		longint unsigned mant;
		logic [19:0] acc;
		mant = (64'd1 << 30) + (longint'(i) << (30 - TBITS));
		acc = '0;
		for (int k = 0; k < 20; k++) begin
			mant = (mant * mant) >> 30;
			acc = {acc[18:0], 1'b0};
			if (mant >= (64'd1 << 31)) begin
				mant = mant >> 1;
				acc[0] = 1'b1;
			end
		end
		return acc;
	endfunction

	function automatic pix_res_t encode_pixel(input logic [31:0] chan [3], input logic last);
		longint a, m, d, lg;
		longint unsigned c [3];
		longint unsigned l, s, idx, n, q, e, prod, v;
		int p;
		logic dark;
		pix_res_t res;
		l = 0;
		m = $signed(min_off);
		for (int j = 0; j < 3; j++) begin
			a = $signed(chan[j]);
			d = a - m;
			c[j] = d > 0 ? longint'(d) : 0;
			if (c[j] > l) l = c[j];
		end
		dark = (l * 10000) < (64'd1 << FRAC);
		for (int j = 0; j < 3; j++) begin
			if (dark) begin
				q = 255;
				e = 0;
			end else if (qmode == QMODE_TRUNC) begin
				n = c[j] * 255;
				q = n / l;
				e = ((n % l) * 255) / l;
				if (e > 255) e = 255;
			end else begin
				q = (2 * c[j] * 255 + l) / (2 * l);
				e = 0;
			end
			if (q > 255) q = 255;
			res.f[j] = q[7:0];
			res.f[4+j] = e[7:0];
		end
		s = l + BLACK_PT;
		p = 0;
		for (int k = 0; k < 40; k++)
			if (s[k]) p = k;
		idx = (p >= TBITS) ? (s >> (p - TBITS)) : (s << (TBITS - p));
		idx &= 64'd255;
		lg = longint'(p - FRAC) * 1048576 + longint'(log2_tab[idx]);
		q = 0;
		e = 0;
		if (lg > 0) begin
			prod = longint'(lg) * longint'({32'd0, lscale});
			if (prod >= (64'd1 << 50)) begin
				q = 255;
				e = (qmode == QMODE_TRUNC) ? 255 : 0;
			end else begin
				v = prod * 255;
				if (qmode == QMODE_TRUNC) begin
					q = v >> 44;
					if (q > 255) begin
						q = 255;
						e = 255;
					end else begin
						e = ((v & ((64'd1 << 44) - 1)) * 255) >> 44;
					end
				end else begin
					q = (v + (64'd1 << 43)) >> 44;
					if (q > 255) q = 255;
				end
			end
		end
		res.f[3] = q[7:0];
		res.f[7] = e[7:0];
		res.last = last;
		return res;
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic int pick_gap();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
	endfunction

	// output side: random stalls, one long hold on request, and the beat check
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_pix.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat %h", m_axis_tdata));
			end else begin
				pix_res_t want;
				want = pending_pix.pop_front();
				for (int j = 0; j < 8; j++)
					if (m_axis_tdata[8*j+:8] !== want.f[j])
						flag_mismatch($sformatf("%s got %0d want %0d", fname[j],
							m_axis_tdata[8*j+:8], want.f[j]));
				if (m_axis_tlast !== want.last)
					flag_mismatch($sformatf("last_out got %b want %b", m_axis_tlast, want.last));
			end
		end
		if (hold_seq != hold_seen) begin
			hold_seen = hold_seq;
			hold_cnt = 80;
		end
		if (hold_cnt > 0) begin
			hold_cnt--;
			m_axis_tready <= 1'b0;
		end else if (stall_cnt > 0) begin
			stall_cnt--;
			m_axis_tready <= 1'b0;
		end else if (!quiet && $urandom_range(0, 3) == 0) begin
			stall_cnt = pick_gap() - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
					|| (cfg_valid && cfg_ready))
				idle_cyc = 0;
			else
				idle_cyc++;
			if (idle_cyc >= IDLE_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	task automatic send_pixel(input logic [31:0] r, g, b, input logic last,
			input logic typed, input logic [63:0] exp);
		logic [31:0] chan [3];
		pix_res_t res;
		int gap;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, g, r};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (typed) begin
			for (int j = 0; j < 8; j++)
				res.f[j] = exp[8*j+:8];
			res.last = last;
		end else begin
			chan[0] = r;
			chan[1] = g;
			chan[2] = b;
			res = encode_pixel(chan, last);
		end
		pending_pix.push_back(res);
		gap = (quiet || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		s_axis_tvalid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (14) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_MIN_VALUE:  min_off = val;
			REG_LOG_SCALE:  lscale = val;
			REG_QUANT_MODE: qmode = val[0];
			default: ;
		endcase
	endtask

	function automatic logic [31:0] near_off();
		case ($urandom_range(0, 4))
			0: return $urandom();
			1: return min_off + $urandom_range(0, 9);
			2: return min_off + $urandom_range(0, 1 << $urandom_range(0, 31));
			3: return min_off - $urandom_range(0, 1000);
			default: return min_off + $urandom_range(0, 1 << 24);
		endcase
	endfunction

	dir_row_t dir_tab [16] = '{
		'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 64'h0000_0000_00FF_FFFF},
		'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 64'h0000_0000_00FF_FFFF},
		'{32'h0000_0006, 32'h0000_0006, 32'h0000_0006, 1'b0, 1'b1, 64'h0000_0000_00FF_FFFF},
		'{32'h0000_0007, 32'h0000_0000, 32'h0000_0000, 1'b0, 1'b1, 64'h0000_0000_0000_00FF},
		'{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 64'h0000_0000_FFFF_FFFF},
		'{32'h7FFF_FFFF, 32'h0000_0000, 32'h8000_0000, 1'b0, 1'b0, 64'h0},
		'{32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 1'b0, 1'b0, 64'h0},
		'{32'h0001_0000, 32'h0000_8000, 32'h0000_4000, 1'b0, 1'b0, 64'h0},
		'{32'h0000_0001, 32'h0000_0003, 32'h0000_0007, 1'b0, 1'b0, 64'h0},
		'{32'h0000_FFFF, 32'h0000_0AB3, 32'h0000_7F00, 1'b1, 1'b0, 64'h0},
		'{32'h1234_5678, 32'h0ABC_DEF0, 32'h7F00_FF00, 1'b0, 1'b0, 64'h0},
		'{32'h5555_5555, 32'hAAAA_AAAA, 32'h3333_3333, 1'b0, 1'b0, 64'h0},
		'{32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0001, 1'b0, 1'b0, 64'h0},
		'{32'h0000_0100, 32'h0000_0080, 32'h0000_007F, 1'b0, 1'b0, 64'h0},
		'{32'h0000_0003, 32'h0000_0001, 32'h0000_0002, 1'b1, 1'b0, 64'h0},
		'{32'h00FF_0000, 32'h0100_0000, 32'h0000_0001, 1'b0, 1'b0, 64'h0}
	};

	logic [31:0] ph_min   [6] = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
		32'hFFFF_0000, 32'h0000_0000, 32'h0001_0000};
	logic [31:0] ph_scale [6] = '{LOG_SCALE_RST, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h0100_0000, 32'h0000_0001, 32'h0400_0000};
	logic        ph_mode  [6] = '{QMODE_ROUND, QMODE_TRUNC, QMODE_ROUND,
		QMODE_TRUNC, QMODE_TRUNC, QMODE_ROUND};

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_MIN_VALUE;
		cfg_data = '0;
		min_off = '0;
		lscale = LOG_SCALE_RST;
		qmode = QMODE_ROUND;
		mismatch_cnt = 0;
		idle_cyc = 0;
		hold_cnt = 0;
		stall_cnt = 0;
		hold_seq = 0;
		hold_seen = 0;
		quiet = 1'b0;
		for (int i = 0; i < 256; i++)
			log2_tab[i] = log2_frac(i);
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int pass = 0; pass < 2; pass++) begin
			if (pass == 1) begin
				write_reg(REG_QUANT_MODE, 32'hFFFF_FFFE | QMODE_TRUNC);
				write_reg(REG_MIN_VALUE, 32'h8000_0000);
			end
			foreach (dir_tab[k])
				send_pixel(dir_tab[k].r, dir_tab[k].g, dir_tab[k].b, dir_tab[k].last,
					dir_tab[k].typed && pass == 0, dir_tab[k].exp);
		end

		for (int ph = 0; ph < 7; ph++) begin
			if (ph < 6) begin
				write_reg(REG_MIN_VALUE, ph_min[ph]);
				write_reg(REG_LOG_SCALE, ph_scale[ph]);
				write_reg(REG_QUANT_MODE, {31'd0, ph_mode[ph]});
			end else begin
				write_reg(REG_MIN_VALUE, $urandom());
				write_reg(REG_LOG_SCALE, $urandom());
				write_reg(REG_QUANT_MODE, $urandom());
			end
			quiet = (ph == 1);
			if (ph == 2)
				hold_seq <= hold_seq + 1;
			repeat (100)
				send_pixel(near_off(), near_off(), near_off(), $urandom_range(0, 1),
					1'b0, 64'h0);
		end

		s_axis_tvalid <= 1'b0;
		while (pending_pix.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
